// ----- src/jsv_pkg.sv -----
// Josephus survivor: shared types and field widths.
// Used by every module of the block; depends on nothing.
package jsv_pkg;

    localparam int N_W = 7;   // circle size and survivor field width
    localparam int K_W = 8;   // step count field width

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } ctrl_state_t;

    // Command from the controller to every cell of the ring
    typedef struct packed {
        logic init;    // load token and presence for a new item
        logic shift;   // move the token one position
        logic remove;  // clear presence where the token lands
    } chain_cmd_t;

endpackage

// ----- src/jsv_cell.sv -----
// Josephus survivor: one ring cell, holding a presence flag and the token bit.
// Depends on jsv_pkg.
module jsv_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  jsv_pkg::chain_cmd_t   cmd,
    input  logic [jsv_pkg::N_W-1:0] n_size,
    input  logic                  tok_in,
    output logic                  tok_out,
    output logic                  alive,
    output logic                  last
);

    localparam logic [jsv_pkg::N_W-1:0] IDX = jsv_pkg::N_W'(CELL_INDEX);

    logic tok_reg, tok_next;
    logic alive_reg, alive_next;

    // last slot of the circle wraps the token back to cell 0
    assign last = (IDX == n_size - jsv_pkg::N_W'(1));

    always_comb begin
        tok_next   = tok_reg;
        alive_next = alive_reg;
        if (cmd.init) begin
            tok_next   = last;
            alive_next = (IDX < n_size);
        end else if (cmd.shift) begin
            tok_next = tok_in;
            if (cmd.remove && tok_in) begin
                alive_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= 1'b0;
            alive_reg <= 1'b0;
        end else begin
            tok_reg   <= tok_next;
            alive_reg <= alive_next;
        end
    end

    assign tok_out = tok_reg;
    assign alive   = alive_reg;

endmodule

// ----- src/jsv_chain.sv -----
// Josephus survivor: ring of cells passing the token, live-landing detect
// and survivor encoder. Depends on jsv_pkg and jsv_cell.
module jsv_chain #(
    parameter int MAX_CIRCLE = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  jsv_pkg::chain_cmd_t     cmd,
    input  logic [jsv_pkg::N_W-1:0] n_size,
    output logic                    hit,
    output logic [jsv_pkg::N_W-1:0] survivor
);

    logic [MAX_CIRCLE-1:0] tok;
    logic [MAX_CIRCLE-1:0] tok_in;
    logic [MAX_CIRCLE-1:0] alive;
    logic [MAX_CIRCLE-1:0] last;

    // token leaving the last slot of the circle re-enters at cell 0
    assign tok_in[0] = |(tok & last);

    genvar g;
    generate
        for (g = 1; g < MAX_CIRCLE; g++) begin : g_link
            assign tok_in[g] = tok[g-1] & ~last[g-1];
        end
        for (g = 0; g < MAX_CIRCLE; g++) begin : g_cell
            jsv_cell #(
                .CELL_INDEX(g)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd),
                .n_size  (n_size),
                .tok_in  (tok_in[g]),
                .tok_out (tok[g]),
                .alive   (alive[g]),
                .last    (last[g])
            );
        end
    endgenerate

    // token is about to land on a live position
    assign hit = |(tok_in & alive);

    // exactly one cell stays live at the end of an item
    always_comb begin
        survivor = '0;
        for (int i = 0; i < MAX_CIRCLE; i++) begin
            if (alive[i]) begin
                survivor = survivor | jsv_pkg::N_W'(i + 1);
            end
        end
    end

endmodule

// ----- src/jsv_ctrl.sv -----
// Josephus survivor: sequencer, step-reduction remainder unit and walk counter.
// Depends on jsv_pkg.
module jsv_ctrl #(
    parameter int MAX_CIRCLE = 64,
    parameter int MAX_STEP   = 255
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [jsv_pkg::N_W-1:0] circle_size,
    input  logic [jsv_pkg::K_W-1:0] step_count,
    input  logic                    hit,
    input  logic                    done_ready,
    output logic                    idle,
    output logic                    done_valid,
    output logic [jsv_pkg::N_W-1:0] n_size,
    output jsv_pkg::chain_cmd_t     cmd
);

    localparam int NW = jsv_pkg::N_W;
    localparam int KW = jsv_pkg::K_W;
    localparam int CW = $clog2(KW);

    jsv_pkg::ctrl_state_t state_reg, state_next;

    logic [NW-1:0] n_reg, n_next;
    logic [KW-1:0] km1_reg, km1_next;       // K-1, copied into ksh_reg and shifted out MSB first
    logic [KW-1:0] ksh_reg, ksh_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [NW-1:0] removals_reg, removals_next;
    logic [NW-1:0] steps_reg, steps_next;

    logic [NW-1:0] n_sat;
    logic [KW-1:0] k_sat;
    logic [16:0]   k_wide;
    logic [NW-1:0] live;
    logic [NW:0]   trial;

    always_comb begin
        n_sat = circle_size;
        if (circle_size == '0) begin
            n_sat = NW'(1);
        end else if (circle_size > NW'(MAX_CIRCLE)) begin
            n_sat = NW'(MAX_CIRCLE);
        end
        k_wide = {{(17-KW){1'b0}}, step_count};
        k_sat  = step_count;
        if (step_count == '0) begin
            k_sat = KW'(1);
        end else if (k_wide > 17'(MAX_STEP)) begin
            k_sat = KW'(MAX_STEP);
        end
    end

    assign live  = n_reg - removals_reg;
    assign trial = {rem_reg, ksh_reg[KW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jsv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        km1_reg      <= km1_next;
        ksh_reg      <= ksh_next;
        rem_reg      <= rem_next;
        bit_cnt_reg  <= bit_cnt_next;
        removals_reg <= removals_next;
        steps_reg    <= steps_next;
    end

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        km1_next      = km1_reg;
        ksh_next      = ksh_reg;
        rem_next      = rem_reg;
        bit_cnt_next  = bit_cnt_reg;
        removals_next = removals_reg;
        steps_next    = steps_reg;
        idle          = 1'b0;
        done_valid    = 1'b0;
        cmd           = '0;

        unique case (state_reg)
            jsv_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    n_next     = n_sat;
                    km1_next   = k_sat - KW'(1);
                    state_next = jsv_pkg::ST_INIT;
                end
            end
            jsv_pkg::ST_INIT: begin
                cmd.init      = 1'b1;
                removals_next = '0;
                rem_next      = '0;
                ksh_next      = km1_reg;
                bit_cnt_next  = '0;
                state_next    = (n_reg == NW'(1)) ? jsv_pkg::ST_DONE : jsv_pkg::ST_DIV;
            end
            jsv_pkg::ST_DIV: begin
                // restoring remainder: (K-1) mod live, one bit per cycle
                if (trial >= {1'b0, live}) begin
                    rem_next = NW'(trial - {1'b0, live});
                end else begin
                    rem_next = NW'(trial);
                end
                ksh_next     = {ksh_reg[KW-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + CW'(1);
                if (bit_cnt_reg == CW'(KW - 1)) begin
                    steps_next = '0;
                    state_next = jsv_pkg::ST_WALK;
                end
            end
            jsv_pkg::ST_WALK: begin
                cmd.shift  = 1'b1;
                cmd.remove = (steps_reg == rem_reg);
                if (hit) begin
                    if (steps_reg == rem_reg) begin
                        removals_next = removals_reg + NW'(1);
                        rem_next      = '0;
                        ksh_next      = km1_reg;
                        bit_cnt_next  = '0;
                        if (removals_reg + NW'(2) == n_reg) begin
                            state_next = jsv_pkg::ST_DONE;
                        end else begin
                            state_next = jsv_pkg::ST_DIV;
                        end
                    end else begin
                        steps_next = steps_reg + NW'(1);
                    end
                end
            end
            jsv_pkg::ST_DONE: begin
                done_valid = 1'b1;
                if (done_ready) begin
                    state_next = jsv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jsv_pkg::ST_IDLE;
            end
        endcase
    end

    assign n_size = n_reg;

endmodule

// ----- src/josephus_survivor_top.sv -----
// Josephus survivor top level: handshake ports, output register, assertions.
// Depends on jsv_pkg, jsv_ctrl and jsv_chain.
//
// Each input item (circle size N, step K) is solved by simulating the
// elimination on a ring of MAX_CIRCLE cells. A token moves one cell per
// clock during each walk around the first N cells; landings on live cells
// are counted, and the cell reached on the last counted landing is
// removed. Before each removal K-1 is reduced modulo the live count by a
// bit-serial remainder unit; the walk then moves the token over each
// position in turn, live or removed. For N=1 the sequencer goes straight
// from init to done. One item is worked on at a time; s_ready is high
// whenever the sequencer is idle, even while a finished survivor still
// waits on m_valid. N of zero acts as 1 and N above MAX_CIRCLE as
// MAX_CIRCLE; K of zero acts as 1 and K above MAX_STEP as MAX_STEP.
// The survivor is one-based.
module josephus_survivor_top #(
    parameter int MAX_CIRCLE = 64,
    parameter int MAX_STEP   = 255
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [jsv_pkg::N_W-1:0] s_circle_size,
    input  logic [jsv_pkg::K_W-1:0] s_step_count,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [jsv_pkg::N_W-1:0] m_survivor
);

    jsv_pkg::chain_cmd_t     cmd;
    logic [jsv_pkg::N_W-1:0] n_size;
    logic [jsv_pkg::N_W-1:0] survivor;
    logic                    hit;
    logic                    idle;
    logic                    done_valid;
    logic                    done_ready;
    logic                    start;

    logic                    m_valid_reg, m_valid_next;
    logic [jsv_pkg::N_W-1:0] survivor_reg, survivor_next;

    assign start      = s_valid & s_ready;
    assign s_ready    = idle;
    // result slot is free, or is being emptied this cycle
    assign done_ready = ~m_valid_reg | m_ready;

    jsv_ctrl #(
        .MAX_CIRCLE (MAX_CIRCLE),
        .MAX_STEP   (MAX_STEP)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .circle_size (s_circle_size),
        .step_count  (s_step_count),
        .hit         (hit),
        .done_ready  (done_ready),
        .idle        (idle),
        .done_valid  (done_valid),
        .n_size      (n_size),
        .cmd         (cmd)
    );

    jsv_chain #(
        .MAX_CIRCLE (MAX_CIRCLE)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .n_size   (n_size),
        .hit      (hit),
        .survivor (survivor)
    );

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg;
        survivor_next = survivor_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (done_valid && done_ready) begin
            m_valid_next  = 1'b1;
            survivor_next = survivor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        survivor_reg <= survivor_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_survivor = survivor_reg;

    // survivor always lies within the ring
    a_surv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_survivor != '0) && (m_survivor <= jsv_pkg::N_W'(MAX_CIRCLE)))
        else $error("survivor out of range");

    // an accepted item leaves the sequencer busy in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("input ready right after accept");

    // a finished item handed to the output register shows up on m_valid
    a_done_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        done_valid && done_ready |=> m_valid)
        else $error("finished item lost");

endmodule

// ----- verif/tb.sv -----
// Testbench for josephus_survivor_top: random and directed circles, checked
// against a behavioral elimination walk kept in this file. Depends on jsv_pkg
// and the josephus_survivor_top RTL.
module tb;

    localparam int MAX_CIRCLE   = 64;
    localparam int MAX_STEP     = 255;
    localparam int CYCLE_LIMIT  = 6000000;  // watchdog limit for the whole run
    localparam int DRAIN_CYCLES = 5000;     // longer than the slowest item

    // One outstanding circle and the survivor it must produce
    typedef struct {
        logic [jsv_pkg::N_W-1:0] circle;
        logic [jsv_pkg::K_W-1:0] step;
        logic [jsv_pkg::N_W-1:0] survivor;
    } circle_job_t;

    logic                    aclk;
    logic                    aresetn       = 1'b0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [jsv_pkg::N_W-1:0] s_circle_size = '0;
    logic [jsv_pkg::K_W-1:0] s_step_count  = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [jsv_pkg::N_W-1:0] m_survivor;

    circle_job_t pending_survivors[$];

    // Idle knobs: each side draws a random idle gap per item, up to its maximum
    int tx_gap_max      = 9;
    int rx_stall_max    = 9;
    int rx_hold_cycles  = 0;   // one-shot long hold-off for the receiver
    int items_sent      = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int cycle_count     = 0;

    josephus_survivor_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_circle_size (s_circle_size),
        .s_step_count  (s_step_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_survivor    (m_survivor)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Elimination walk: clamp N and K, then N-1 times hop over live positions
    // and remove where the hop ends. Long steps are folded modulo the live
    // count, which lands on the same position.
    function automatic logic [jsv_pkg::N_W-1:0] last_standing(
        input logic [jsv_pkg::N_W-1:0] n_in,
        input logic [jsv_pkg::K_W-1:0] k_in
    );
        int                  n;
        int                  k;
        int                  live;
        int                  hops;
        int                  pos;
        int                  out_count;
        int                  idx;
        int                  left;
        bit [MAX_CIRCLE-1:0] gone;
        n = (n_in == 0) ? 1 : ((int'(n_in) > MAX_CIRCLE) ? MAX_CIRCLE : int'(n_in));
        k = (k_in == 0) ? 1 : ((int'(k_in) > MAX_STEP) ? MAX_STEP : int'(k_in));
        gone = '0;
        pos  = n - 1;                     // just before position 1
        for (out_count = 0; out_count + 1 < n; out_count++) begin
            live = n - out_count;
            hops = ((k - 1) % live) + 1;
            repeat (hops) begin
                pos = (pos + 1) % n;
                while (gone[pos])
                    pos = (pos + 1) % n;
            end
            gone[pos] = 1'b1;
        end
        left = 0;
        for (idx = n - 1; idx >= 0; idx--)
            if (!gone[idx])
                left = idx;
        return jsv_pkg::N_W'(left + 1);
    endfunction

    // Offer one item after a random gap; valid stays up when the gap is zero.
    // Returns at the edge where the item is taken.
    task automatic offer_circle(input logic [jsv_pkg::N_W-1:0] n,
                                input logic [jsv_pkg::K_W-1:0] k);
        int          gap;
        circle_job_t job;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_circle_size <= n;
        s_step_count  <= k;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        job.circle   = n;
        job.step     = k;
        job.survivor = last_standing(n, k);
        pending_survivors.push_back(job);
        items_sent++;
    endtask

    // Mostly small circles so the run stays short; a few large ones, from 41
    // up to and beyond the maximum, where the walk is longest.
    task automatic offer_random_circle();
        int                      pick;
        logic [jsv_pkg::N_W-1:0] n;
        logic [jsv_pkg::K_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            n = '0;
        else if (pick < 72)
            n = jsv_pkg::N_W'($urandom_range(1, 12));
        else if (pick < 93)
            n = jsv_pkg::N_W'($urandom_range(13, 40));
        else
            n = jsv_pkg::N_W'($urandom_range(41, 127));
        if ($urandom_range(0, 3) == 0)
            k = jsv_pkg::K_W'($urandom_range(0, 4));
        else
            k = jsv_pkg::K_W'($urandom_range(0, 255));
        offer_circle(n, k);
    endtask

    // Result side: random stalls, one long hold-off when asked, then compare
    // each accepted survivor with the oldest outstanding circle.
    initial begin : survivor_check
        int          wait_cycles;
        circle_job_t due;
        do
            @(posedge aclk);
        while (!aresetn);
        forever begin
            if (rx_hold_cycles > 0) begin
                wait_cycles    = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, rx_stall_max);
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            results_checked++;
            if (pending_survivors.size() == 0) begin
                $error("survivor: result %0d arrived with no item outstanding",
                       m_survivor);
                fail_count++;
            end else begin
                due = pending_survivors.pop_front();
                if (m_survivor !== due.survivor) begin
                    $error("survivor (N=%0d K=%0d): expected %0d, actual %0d",
                           due.circle, due.step, due.survivor, m_survivor);
                    fail_count++;
                end
            end
        end
    end

    // Field extremes, clamping of out-of-range N and K, folded long steps
    task automatic test_directed();
        offer_circle(7'd1,   8'd1);
        offer_circle(7'd0,   8'd0);     // zero size and zero step
        offer_circle(7'd1,   8'd255);
        offer_circle(7'd2,   8'd1);
        offer_circle(7'd2,   8'd2);
        offer_circle(7'd7,   8'd3);
        offer_circle(7'd41,  8'd3);
        offer_circle(7'd5,   8'd64);    // step far above the live count
        offer_circle(7'd10,  8'd0);
        offer_circle(7'd3,   8'd128);
        offer_circle(7'd63,  8'd170);
        offer_circle(7'd64,  8'd1);
        offer_circle(7'd64,  8'd255);
        offer_circle(7'd65,  8'd2);     // just above the ring size
        offer_circle(7'd127, 8'd0);     // all size bits set
        offer_circle(7'd85,  8'd85);
        offer_circle(7'd42,  8'd254);
    endtask

    task automatic test_random_idle();
        tx_gap_max   = 9;
        rx_stall_max = 9;
        repeat (130) offer_random_circle();
    endtask

    task automatic test_back_to_back();
        tx_gap_max   = 0;
        rx_stall_max = 0;
        repeat (60) offer_random_circle();
    endtask

    // Receiver stops for a long time while small circles keep coming, so the
    // output register and the sequencer both fill and s_ready drops.
    task automatic test_output_backpressure();
        tx_gap_max     = 0;
        rx_stall_max   = 0;
        rx_hold_cycles = 3000;
        repeat (20)
            offer_circle(jsv_pkg::N_W'($urandom_range(1, 8)),
                         jsv_pkg::K_W'($urandom_range(0, 255)));
    endtask

    task automatic test_slow_receiver();
        tx_gap_max   = 0;
        rx_stall_max = 9;
        repeat (60) offer_random_circle();
    endtask

    initial begin : run_tests
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_idle();
        test_back_to_back();
        test_output_backpressure();
        test_slow_receiver();
        s_valid <= 1'b0;
        while (pending_survivors.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Ran %0d circles (sizes 0..127, steps 0..255) with idle, back-to-back",
                 items_sent);
        $display("and held-off traffic; %0d survivors checked", results_checked);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
